// ===== src/mmpe_pkg.sv =====
// Shared types and constants for the mouse motion packet encoder.
package mmpe_pkg;

   // Operation codes carried on the request channel
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_READ   = 1'b1;

   // Packet framing
   localparam logic [7:0] SYNC_BIT    = 8'h80;
   localparam logic [2:0] BUTTON_MASK = 3'h7;
   localparam int         CLAMP_HI    = 127;
   localparam int         STORE_BYTES = 3;

   // One request item
   typedef struct packed {
      logic              operation;
      logic signed [7:0] delta_x;
      logic signed [7:0] delta_y;
      logic [2:0]        buttons;
   } req_type;

   // One result item
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       last_byte;
      logic       data_ready;
   } result_type;

endpackage

// ===== src/mmpe_if.sv =====
// Valid/ready channel interfaces for the request and result sides.
interface mmpe_req_if;
   logic              valid;
   logic              ready;
   logic              operation;
   logic signed [7:0] delta_x;
   logic signed [7:0] delta_y;
   logic [2:0]        buttons;

   modport source (output valid, operation, delta_x, delta_y, buttons, input ready);
   modport sink   (input valid, operation, delta_x, delta_y, buttons, output ready);
endinterface

interface mmpe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       last_byte;
   logic       data_ready;

   modport source (output valid, data_byte, byte_valid, last_byte, data_ready, input ready);
   modport sink   (input valid, data_byte, byte_valid, last_byte, data_ready, output ready);
endinterface

// ===== src/mmpe_state.sv =====
// Accumulators, button tracking, packet latch and byte sequencing.
module mmpe_state #(
   parameter int ACCUM_WIDTH  = 16,
   parameter int PACKET_BYTES = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_fire,
   input  mmpe_pkg::req_type      item,
   output mmpe_pkg::result_type   res
);

   localparam int IDX_W = $clog2(PACKET_BYTES + 1);
   localparam logic [IDX_W-1:0] PB_IDX    = IDX_W'(PACKET_BYTES);
   localparam logic [IDX_W-1:0] STORE_IDX = IDX_W'(mmpe_pkg::STORE_BYTES);
   localparam logic signed [ACCUM_WIDTH:0] ACC_MAX = {2'b00, {(ACCUM_WIDTH-1){1'b1}}};
   localparam logic signed [ACCUM_WIDTH:0] ACC_MIN = {2'b11, {(ACCUM_WIDTH-1){1'b0}}};
   localparam logic signed [ACCUM_WIDTH:0] LIM_HI  = (ACCUM_WIDTH+1)'(mmpe_pkg::CLAMP_HI);
   localparam logic signed [ACCUM_WIDTH:0] LIM_LO  = -LIM_HI;

   logic signed [ACCUM_WIDTH-1:0] acc_x_ff, acc_x_in;
   logic signed [ACCUM_WIDTH-1:0] acc_y_ff, acc_y_in;
   logic [2:0]                    btn_now_ff, btn_now_in;
   logic [2:0]                    btn_sent_ff, btn_sent_in;
   logic [IDX_W-1:0]              idx_ff, idx_in;
   logic [7:0]                    store_ff [mmpe_pkg::STORE_BYTES];

   logic signed [ACCUM_WIDTH:0]   sum_x, sum_y, ext_x, neg_y, clip_x, clip_y;
   logic                          pending, latch;
   logic [7:0]                    new_b0;
   logic [7:0]                    rd_byte;

   // Saturating sums of the accumulators with the sign-extended deltas
   assign sum_x = {acc_x_ff[ACCUM_WIDTH-1], acc_x_ff} + (ACCUM_WIDTH+1)'(item.delta_x);
   assign sum_y = {acc_y_ff[ACCUM_WIDTH-1], acc_y_ff} + (ACCUM_WIDTH+1)'(item.delta_y);

   // Packet field values: x clamped, y negated and clamped
   assign ext_x  = {acc_x_ff[ACCUM_WIDTH-1], acc_x_ff};
   assign neg_y  = -{acc_y_ff[ACCUM_WIDTH-1], acc_y_ff};
   assign clip_x = (ext_x > LIM_HI) ? LIM_HI : ((ext_x < LIM_LO) ? LIM_LO : ext_x);
   assign clip_y = (neg_y > LIM_HI) ? LIM_HI : ((neg_y < LIM_LO) ? LIM_LO : neg_y);
   assign new_b0 = mmpe_pkg::SYNC_BIT | {5'b0, btn_now_ff & mmpe_pkg::BUTTON_MASK};

   assign pending = (acc_x_ff != '0) || (acc_y_ff != '0) || (btn_now_ff != btn_sent_ff);
   assign latch   = in_fire && (item.operation == mmpe_pkg::OP_READ)
                    && (idx_ff >= PB_IDX) && pending;

   // Byte returned on a read; a fresh latch reads byte 0 directly
   always_comb begin
      if (latch) begin
         rd_byte = new_b0;
      end else if (idx_ff < STORE_IDX) begin
         rd_byte = store_ff[idx_ff[1:0]];
      end else begin
         rd_byte = '0;
      end
   end

   // Next state and result
   always_comb begin
      acc_x_in        = acc_x_ff;
      acc_y_in        = acc_y_ff;
      btn_now_in      = btn_now_ff;
      btn_sent_in     = btn_sent_ff;
      idx_in          = idx_ff;
      res.data_byte   = '0;
      res.byte_valid  = 1'b0;
      res.last_byte   = 1'b0;
      if (in_fire) begin
         if (item.operation == mmpe_pkg::OP_SAMPLE) begin
            acc_x_in   = (sum_x > ACC_MAX) ? ACC_MAX[ACCUM_WIDTH-1:0] :
                         (sum_x < ACC_MIN) ? ACC_MIN[ACCUM_WIDTH-1:0] :
                         sum_x[ACCUM_WIDTH-1:0];
            acc_y_in   = (sum_y > ACC_MAX) ? ACC_MAX[ACCUM_WIDTH-1:0] :
                         (sum_y < ACC_MIN) ? ACC_MIN[ACCUM_WIDTH-1:0] :
                         sum_y[ACCUM_WIDTH-1:0];
            btn_now_in = item.buttons & mmpe_pkg::BUTTON_MASK;
         end else if (latch || (idx_ff < PB_IDX)) begin
            if (latch) begin
               acc_x_in    = '0;
               acc_y_in    = '0;
               btn_sent_in = btn_now_ff;
            end
            idx_in         = (latch ? '0 : idx_ff) + IDX_W'(1);
            res.data_byte  = rd_byte;
            res.byte_valid = 1'b1;
            res.last_byte  = (idx_in >= PB_IDX);
         end
      end
      res.data_ready = (idx_in < PB_IDX) || (acc_x_in != '0) || (acc_y_in != '0)
                       || (btn_now_in != btn_sent_in);
   end

   // Control and accumulator state
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_x_ff    <= '0;
         acc_y_ff    <= '0;
         btn_now_ff  <= mmpe_pkg::BUTTON_MASK;
         btn_sent_ff <= mmpe_pkg::BUTTON_MASK;
         idx_ff      <= PB_IDX;
      end else begin
         acc_x_ff    <= acc_x_in;
         acc_y_ff    <= acc_y_in;
         btn_now_ff  <= btn_now_in;
         btn_sent_ff <= btn_sent_in;
         idx_ff      <= idx_in;
      end
   end

   // Latched packet bytes, no reset
   always_ff @(posedge clock) begin
      if (latch) begin
         store_ff[0] <= new_b0;
         store_ff[1] <= clip_x[7:0];
         store_ff[2] <= clip_y[7:0];
      end
   end

`ifndef SYNTH
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= PB_IDX)
      else $error("byte index beyond packet length");

   a_latch_clears: assert property (@(posedge clock) disable iff (reset)
      latch |=> (acc_x_ff == '0) && (acc_y_ff == '0) && (btn_sent_ff == $past(btn_now_ff)))
      else $error("packet latch did not clear pending state");

   a_read_advances: assert property (@(posedge clock) disable iff (reset)
      (in_fire && res.byte_valid) |=> (idx_ff == ($past(latch) ? IDX_W'(1)
                                                 : $past(idx_ff) + IDX_W'(1))))
      else $error("byte index did not advance on a delivered byte");

   a_last_is_byte: assert property (@(posedge clock) disable iff (reset)
      res.last_byte |-> (res.byte_valid && !(idx_in < PB_IDX)))
      else $error("last byte flagged without a final packet byte");
`endif

endmodule

// ===== src/mmpe_out_reg.sv =====
// Result register that decouples the result channel from the request side.
module mmpe_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  mmpe_pkg::result_type res_in,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output mmpe_pkg::result_type res_out,
   output logic                 can_accept
);

   logic                 valid_ff, valid_in;
   mmpe_pkg::result_type res_ff;

   // Space is free when empty or when the held result leaves this cycle
   assign can_accept = !valid_ff || rsp_ready;
   assign valid_in   = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign res_out   = res_ff;

`ifndef SYNTH
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> can_accept)
      else $error("result register loaded while holding an untaken result");
`endif

endmodule

// ===== src/mouse_motion_packet_encoder.sv =====
// Top level of the mouse motion packet encoder.
//
// Request channel (req_if): each transfer is either a motion sample
// (operation 0: delta_x, delta_y, active-low buttons) or a read of one
// packet byte (operation 1). Result channel (rsp_if): exactly one result
// per request, in order, carrying data_byte, byte_valid, last_byte and
// data_ready (bytes left or movement/buttons pending after this request).
// A read with nothing pending and no packet open returns byte_valid 0.
// The result is registered and presented in the cycle after the request transfer.
// Throughput: one request per cycle unless rsp_if stalls; all work for
// an item is done in the single logic stage ahead of the result register.
// Reset (synchronous): accumulators zero, buttons all released, no packet
// open, result register empty. The packet bytes themselves are not reset.
// Stall: while the receiver holds rsp_if.ready low the result register
// keeps its item and req_if.ready drops; it rises again in the cycle the
// held result is taken.
module mouse_motion_packet_encoder #(
   parameter int ACCUM_WIDTH  = 16,
   parameter int PACKET_BYTES = 5
) (
   input  logic       clock,
   input  logic       reset,
   mmpe_req_if.sink   req_if,
   mmpe_rsp_if.source rsp_if
);

   mmpe_pkg::req_type    item;
   mmpe_pkg::result_type res_next;
   mmpe_pkg::result_type res_held;
   logic                 can_accept;
   logic                 in_fire;

   // Request transfer
   assign item.operation = req_if.operation;
   assign item.delta_x   = req_if.delta_x;
   assign item.delta_y   = req_if.delta_y;
   assign item.buttons   = req_if.buttons;
   assign req_if.ready   = can_accept;
   assign in_fire        = req_if.valid && can_accept;

   mmpe_state #(
      .ACCUM_WIDTH  (ACCUM_WIDTH),
      .PACKET_BYTES (PACKET_BYTES)
   ) u_state (
      .clock   (clock),
      .reset   (reset),
      .in_fire (in_fire),
      .item    (item),
      .res     (res_next)
   );

   mmpe_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (in_fire),
      .res_in     (res_next),
      .rsp_ready  (rsp_if.ready),
      .rsp_valid  (rsp_if.valid),
      .res_out    (res_held),
      .can_accept (can_accept)
   );

   // Result payload
   assign rsp_if.data_byte  = res_held.data_byte;
   assign rsp_if.byte_valid = res_held.byte_valid;
   assign rsp_if.last_byte  = res_held.last_byte;
   assign rsp_if.data_ready = res_held.data_ready;

endmodule

// ===== sim/tb_mouse_motion_packet_encoder.sv =====
// Self-checking testbench for the mouse motion packet encoder, random stalls on both channels.
module tb_mouse_motion_packet_encoder;

   localparam int ACCUM_WIDTH  = 16;
   localparam int PACKET_BYTES = 5;
   localparam int ACC_MAX      = (1 << (ACCUM_WIDTH - 1)) - 1;
   localparam int ACC_MIN      = -ACC_MAX - 1;
   localparam int RANDOM_ITEMS = 400;
   localparam int SAT_SAMPLES  = 260;
   localparam int TAIL_CYCLES  = 5;

   typedef struct {
      mmpe_pkg::req_type item;
      bit                wait_drain;
   } queued_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mmpe_req_if req_if ();
   mmpe_rsp_if rsp_if ();

   mouse_motion_packet_encoder #(
      .ACCUM_WIDTH (ACCUM_WIDTH),
      .PACKET_BYTES(PACKET_BYTES)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   // Clock, period 10
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Inputs known from time zero
   initial begin
      req_if.valid     = 1'b0;
      req_if.operation = mmpe_pkg::OP_SAMPLE;
      req_if.delta_x   = '0;
      req_if.delta_y   = '0;
      req_if.buttons   = mmpe_pkg::BUTTON_MASK;
      rsp_if.ready     = 1'b0;
   end

   // Predictor state
   int         acc_x = 0;
   int         acc_y = 0;
   logic [2:0] btn_now = mmpe_pkg::BUTTON_MASK;
   logic [2:0] btn_sent = mmpe_pkg::BUTTON_MASK;
   logic [7:0] packet_bytes [mmpe_pkg::STORE_BYTES];
   int         next_byte = PACKET_BYTES;

   queued_req_type       req_backlog[$];
   mmpe_pkg::result_type owed_results[$];

   int                   accepted = 0;
   int                   checked = 0;
   int                   errors = 0;
   int                   send_wait = 0;
   int                   take_wait = 0;
   mmpe_pkg::result_type got_res;
   mmpe_pkg::result_type want_res;

   // Stimulus generator state
   logic [2:0] gen_btn = mmpe_pkg::BUTTON_MASK;
   int         random_count = 0;

   function automatic int sat_add(int a, logic signed [7:0] d);
      int s;
      s = a + int'(d);
      if (s > ACC_MAX) s = ACC_MAX;
      if (s < ACC_MIN) s = ACC_MIN;
      return s;
   endfunction

   function automatic logic [7:0] clamp_byte(int v);
      int c;
      c = v;
      if (c > mmpe_pkg::CLAMP_HI) c = mmpe_pkg::CLAMP_HI;
      if (c < -mmpe_pkg::CLAMP_HI) c = -mmpe_pkg::CLAMP_HI;
      return c[7:0];
   endfunction

   function automatic bit motion_pending();
      return acc_x != 0 || acc_y != 0
             || ((btn_now ^ btn_sent) & mmpe_pkg::BUTTON_MASK) != 3'b000;
   endfunction

   // Advance the predictor by one request and return the result it owes
   function automatic mmpe_pkg::result_type encode_next(mmpe_pkg::req_type r);
      mmpe_pkg::result_type res;
      bit                   have;
      res  = '0;
      have = 1'b1;
      if (r.operation == mmpe_pkg::OP_SAMPLE) begin
         acc_x   = sat_add(acc_x, r.delta_x);
         acc_y   = sat_add(acc_y, r.delta_y);
         btn_now = r.buttons;
      end else begin
         // no packet open: latch a fresh one only if something changed
         if (next_byte >= PACKET_BYTES) begin
            if (motion_pending()) begin
               packet_bytes[0] = mmpe_pkg::SYNC_BIT
                                 | {5'b0, btn_now & mmpe_pkg::BUTTON_MASK};
               packet_bytes[1] = clamp_byte(acc_x);
               packet_bytes[2] = clamp_byte(-acc_y);
               btn_sent  = btn_now;
               acc_x     = 0;
               acc_y     = 0;
               next_byte = 0;
            end else begin
               have = 1'b0;
            end
         end
         if (have) begin
            res.data_byte  = (next_byte < mmpe_pkg::STORE_BYTES) ? packet_bytes[next_byte]
                                                                  : 8'h00;
            res.byte_valid = 1'b1;
            next_byte++;
            res.last_byte  = (next_byte >= PACKET_BYTES);
         end
      end
      res.data_ready = (next_byte < PACKET_BYTES) || motion_pending();
      return res;
   endfunction

   // Idle length for the next transfer; some stretches run with no gaps
   function automatic int pick_wait(int n);
      if ((n / 64) % 4 == 1) return 0;
      return $urandom_range(0, 12);
   endfunction

   task automatic report(string field, int got, int want);
      errors++;
      if (errors <= 40)
         $display("result %0d: %s is %0h, expected %0h", checked, field, got, want);
   endtask

   task automatic add_req(logic op, logic [7:0] dx, logic [7:0] dy, logic [2:0] btn,
                          bit drain = 1'b0);
      queued_req_type q;
      q.item.operation = op;
      q.item.delta_x   = dx;
      q.item.delta_y   = dy;
      q.item.buttons   = btn;
      q.wait_drain     = drain;
      req_backlog.push_back(q);
      if (op == mmpe_pkg::OP_SAMPLE) gen_btn = btn;
   endtask

   // Read with junk in the fields a read ignores
   task automatic add_read(bit drain = 1'b0);
      add_req(mmpe_pkg::OP_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              3'($urandom_range(0, 7)), drain);
   endtask

   function automatic logic [7:0] rand_delta();
      if ($urandom_range(0, 2) == 0) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(0, 8) - 4);
   endfunction

   function automatic logic [2:0] rand_buttons();
      if ($urandom_range(0, 1) == 0) return gen_btn;
      return 3'($urandom_range(0, 7));
   endfunction

   // Driver: presents queued requests, holds while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         send_wait = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            owed_results.push_back(encode_next(req_backlog[0].item));
            void'(req_backlog.pop_front());
            accepted++;
            send_wait = pick_wait(accepted);
         end
         if (!(req_if.valid && !req_if.ready)) begin
            if (send_wait > 0) begin
               send_wait--;
               req_if.valid <= 1'b0;
            end else if (req_backlog.size() != 0 &&
                         !(req_backlog[0].wait_drain && owed_results.size() != 0)) begin
               req_if.valid     <= 1'b1;
               req_if.operation <= req_backlog[0].item.operation;
               req_if.delta_x   <= req_backlog[0].item.delta_x;
               req_if.delta_y   <= req_backlog[0].item.delta_y;
               req_if.buttons   <= req_backlog[0].item.buttons;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: takes results with random stalls and checks them in order
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         take_wait = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got_res.data_byte  = rsp_if.data_byte;
            got_res.byte_valid = rsp_if.byte_valid;
            got_res.last_byte  = rsp_if.last_byte;
            got_res.data_ready = rsp_if.data_ready;
            if (owed_results.size() == 0) begin
               report("unexpected result, data_byte", got_res.data_byte, 0);
            end else begin
               want_res = owed_results.pop_front();
               if (got_res.data_byte !== want_res.data_byte)
                  report("data_byte", got_res.data_byte, want_res.data_byte);
               if (got_res.byte_valid !== want_res.byte_valid)
                  report("byte_valid", got_res.byte_valid, want_res.byte_valid);
               if (got_res.last_byte !== want_res.last_byte)
                  report("last_byte", got_res.last_byte, want_res.last_byte);
               if (got_res.data_ready !== want_res.data_ready)
                  report("data_ready", got_res.data_ready, want_res.data_ready);
            end
            checked++;
            take_wait = pick_wait(checked);
            rsp_if.ready <= (take_wait == 0);
         end else if (!rsp_if.ready) begin
            if (take_wait > 0) take_wait--;
            rsp_if.ready <= (take_wait == 0);
         end
      end
   end

   // Stimulus, reset and end of run
   initial begin
      int  n;
      int  kind;
      bit  sat_done;
      bit  drain_done;
      logic [7:0] sx;
      logic [7:0] sy;

      sat_done   = 1'b0;
      drain_done = 1'b0;

      // directed: read with nothing pending, extremes, packet framing
      add_read();
      add_req(mmpe_pkg::OP_SAMPLE, 8'h7f, 8'h80, 3'h7);
      repeat (PACKET_BYTES) add_read();
      add_read();
      // button change alone opens a packet
      add_req(mmpe_pkg::OP_SAMPLE, 8'h00, 8'h00, 3'h0);
      repeat (2) add_read();
      // motion mid-packet is kept for the next one
      add_req(mmpe_pkg::OP_SAMPLE, 8'h80, 8'h7f, 3'h5);
      repeat (PACKET_BYTES - 2) add_read();
      repeat (PACKET_BYTES) add_read();
      // same buttons, no motion: nothing to send
      add_req(mmpe_pkg::OP_SAMPLE, 8'h00, 8'h00, 3'h5);
      add_read();
      add_req(mmpe_pkg::OP_SAMPLE, 8'h01, 8'hff, 3'h2);
      repeat (PACKET_BYTES) add_read();

      // random sequences, mostly whole packets
      while (random_count < RANDOM_ITEMS) begin
         if (!sat_done && random_count >= 60) begin
            // drive both accumulators into saturation
            sx = ($urandom_range(0, 1) != 0) ? 8'h7f : 8'h80;
            sy = ($urandom_range(0, 1) != 0) ? 8'h7f : 8'h80;
            repeat (SAT_SAMPLES) add_req(mmpe_pkg::OP_SAMPLE, sx, sy, gen_btn);
            add_read(1'b1);
            repeat (PACKET_BYTES - 1) add_read();
            random_count += SAT_SAMPLES + PACKET_BYTES;
            sat_done   = 1'b1;
            drain_done = 1'b1;
            continue;
         end
         kind = $urandom_range(0, 9);
         n    = $urandom_range(1, 4);
         if (kind <= 5) begin
            add_req(mmpe_pkg::OP_SAMPLE, rand_delta(), rand_delta(), rand_buttons(),
                    $urandom_range(0, 15) == 0);
            repeat (n - 1)
               add_req(mmpe_pkg::OP_SAMPLE, rand_delta(), rand_delta(), rand_buttons());
            repeat (PACKET_BYTES) add_read();
            random_count += n + PACKET_BYTES;
         end else if (kind == 6) begin
            repeat (n) add_read();
            add_req(mmpe_pkg::OP_SAMPLE, rand_delta(), rand_delta(), rand_buttons());
            random_count += n + 1;
         end else if (kind == 7) begin
            repeat (n + 2) begin
               if ($urandom_range(0, 1) != 0) add_read();
               else add_req(mmpe_pkg::OP_SAMPLE, 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
            end
            random_count += n + 2;
         end else if (kind == 8) begin
            add_read();
            add_read();
            random_count += 2;
         end else begin
            add_req(mmpe_pkg::OP_SAMPLE, 8'h00, 8'h00, gen_btn);
            add_read();
            random_count += 2;
         end
      end
      if (!drain_done) add_read(1'b1);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (req_backlog.size() != 0 || owed_results.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (errors == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
